// File: rtl/etc_pkg.sv
`default_nettype none

package etc_pkg;

    localparam int MAX_CELLS_DEF = 4096;
    localparam int BIN_BITS_DEF  = 8;

    localparam int IN_W        = 8;
    localparam int VIS_IN_W    = 12;
    localparam int ENV_W       = 24;
    localparam int VIS_W       = 28;
    localparam int COST_W      = 22;
    localparam int SCORE_W     = 19;
    localparam int FRAC_W      = 16;
    localparam int VIS_FRAC_W  = 4;
    localparam int VSTEP_W     = 14;
    localparam int PROD_W      = ENV_W + FRAC_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int WEIGHT_W    = 17;
    localparam int BLEND_W     = 37;
    localparam int SCORE_LIM   = 131072;
    localparam int ONE         = 65536;

    localparam int DB_W        = 9;
    localparam int ADM_W       = 17;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [DB_W-1:0]  DB_RESET  = 9'd16;
    localparam logic [ADM_W-1:0] ADM_RESET = 17'h10000;

    localparam logic DIV_SEL_A = 1'b0;
    localparam logic DIV_SEL_V = 1'b1;

    typedef enum logic [0:0] {
        REG_DEPTH_BINS    = 1'b0,
        REG_ADMISSIBILITY = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_RUN,
        S_DEN,
        S_START_A,
        S_WAIT_A,
        S_START_V,
        S_WAIT_V,
        S_MUL,
        S_SUM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accum;
        logic load_plain;
        logic load_merge;
        logic calc_den;
        logic div_start;
        logic div_sel;
        logic take_q;
        logic mul;
        logic sum;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/etc_div.sv
`default_nettype none

module etc_div #(
    parameter int NUM_W = etc_pkg::NUM_W,
    parameter int DEN_W = 22
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);

    localparam int STEP_W = $clog2(NUM_W);

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: rtl/etc_ctrl.sv
`default_nettype none

module etc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_last,
    input  wire logic          i_out_ready,
    input  wire etc_pkg::t_sts i_sts,
    output logic               o_ready,
    output etc_pkg::t_cmd      o_cmd
);

    etc_pkg::t_state r_state;
    etc_pkg::t_state n_state;
    logic            w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etc_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_ready  = 1'b0;
        w_accept = 1'b0;
        case (r_state)
            etc_pkg::S_RUN: begin
                o_ready          = !i_sts.out_valid || i_out_ready;
                w_accept         = o_ready && i_valid;
                o_cmd.accum      = w_accept;
                o_cmd.load_plain = w_accept && !i_last;
                o_cmd.load_merge = w_accept && i_last;
                if (w_accept && i_last) begin
                    n_state = etc_pkg::S_DEN;
                end
            end
            etc_pkg::S_DEN: begin
                o_cmd.calc_den = 1'b1;
                n_state        = etc_pkg::S_START_A;
            end
            etc_pkg::S_START_A: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = etc_pkg::DIV_SEL_A;
                n_state         = etc_pkg::S_WAIT_A;
            end
            etc_pkg::S_WAIT_A: begin
                o_cmd.div_sel = etc_pkg::DIV_SEL_A;
                if (i_sts.div_done) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = etc_pkg::S_START_V;
                end
            end
            etc_pkg::S_START_V: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = etc_pkg::DIV_SEL_V;
                n_state         = etc_pkg::S_WAIT_V;
            end
            etc_pkg::S_WAIT_V: begin
                o_cmd.div_sel = etc_pkg::DIV_SEL_V;
                if (i_sts.div_done) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = etc_pkg::S_MUL;
                end
            end
            etc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = etc_pkg::S_SUM;
            end
            etc_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = etc_pkg::S_FIN;
            end
            etc_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = etc_pkg::S_RUN;
            end
            default: begin
                n_state = etc_pkg::S_RUN;
            end
        endcase
    end

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> !o_ready)
        else $error("input not stalled after final cell");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == etc_pkg::S_WAIT_A || r_state == etc_pkg::S_WAIT_V))
        else $error("divider done outside a wait state");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.out_valid)
        else $error("score word would overwrite a pending word");

endmodule

`default_nettype wire

// File: rtl/etc_datapath.sv
`default_nettype none

module etc_datapath #(
    parameter int MAX_CELLS = etc_pkg::MAX_CELLS_DEF,
    parameter int BIN_BITS  = etc_pkg::BIN_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire etc_pkg::t_cmd                      i_cmd,
    output etc_pkg::t_sts                           o_sts,
    input  wire logic [etc_pkg::IN_W-1:0]           i_near_mine,
    input  wire logic [etc_pkg::IN_W-1:0]           i_near_theirs,
    input  wire logic [etc_pkg::IN_W-1:0]           i_far_mine,
    input  wire logic [etc_pkg::IN_W-1:0]           i_far_theirs,
    input  wire logic [etc_pkg::VIS_IN_W-1:0]       i_vis_mine,
    input  wire logic [etc_pkg::VIS_IN_W-1:0]       i_vis_theirs,
    input  wire logic [etc_pkg::DB_W-1:0]           i_depth_bins,
    input  wire logic [etc_pkg::ADM_W-1:0]          i_admissibility,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [etc_pkg::IN_W-1:0]                o_merged_near,
    output logic [etc_pkg::IN_W-1:0]                o_merged_far,
    output logic                                    o_scores_valid,
    output logic signed [etc_pkg::SCORE_W-1:0]      o_env_score,
    output logic signed [etc_pkg::SCORE_W-1:0]      o_blended_score,
    output logic [etc_pkg::COST_W-1:0]              o_pair_cost
);

    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int Z_W      = BIN_BITS + 1;
    localparam int DEN_W    = CNT_W + Z_W;
    localparam int ESTEP_W  = BIN_BITS + 2;
    localparam int CSTEP_W  = BIN_BITS + 1;
    localparam int DBW      = etc_pkg::DB_W;
    localparam int INW      = etc_pkg::IN_W;
    localparam int ENVW     = etc_pkg::ENV_W;
    localparam int VISW     = etc_pkg::VIS_W;
    localparam int COSTW    = etc_pkg::COST_W;
    localparam int SCW      = etc_pkg::SCORE_W;
    localparam int PRODW    = etc_pkg::PROD_W;
    localparam int NUMW     = etc_pkg::NUM_W;
    localparam int VSW      = etc_pkg::VSTEP_W;
    localparam int WW       = etc_pkg::WEIGHT_W;
    localparam int BLW      = etc_pkg::BLEND_W;
    localparam int ADMW     = etc_pkg::ADM_W;
    localparam int FRACW    = etc_pkg::FRAC_W;
    localparam int VSHIFT   = etc_pkg::FRAC_W - etc_pkg::VIS_FRAC_W;
    localparam logic [DBW-1:0] Z_MAX = DBW'(1 << BIN_BITS);

    // per-cell terms
    logic [BIN_BITS-1:0]        w_nm, w_nt, w_fm, w_ft;
    logic [BIN_BITS-1:0]        w_nmin, w_nmax, w_fmin, w_fmax;
    logic [DBW-1:0]             w_db_c;
    logic [Z_W-1:0]             w_z;
    logic [BIN_BITS-1:0]        w_zm1;
    logic [etc_pkg::VIS_IN_W-1:0] w_vmin, w_vmax, w_vdiff;
    logic [BIN_BITS+3:0]        w_top;
    logic signed [ESTEP_W-1:0]  w_env_step;
    logic signed [VSW-1:0]      w_vis_step;
    logic [CSTEP_W-1:0]         w_cstep;
    logic [COSTW:0]             w_csum;
    logic                       w_room;

    // sums
    logic signed [ENVW-1:0]     r_env;
    logic signed [VISW-1:0]     r_vis;
    logic [COSTW-1:0]           r_cost;
    logic [CNT_W-1:0]           r_cnt;
    logic [DEN_W-1:0]           r_den;

    // division
    logic signed [PRODW-1:0]    w_env_prod, w_vis_prod;
    logic [PRODW-1:0]           w_env_mag, w_vis_mag, w_mag;
    logic [NUMW-1:0]            w_num;
    logic [NUMW-1:0]            w_quo;
    logic                       w_div_done;
    logic                       w_neg;
    logic [SCW-1:0]             w_qsat;
    logic signed [SCW-1:0]      w_score;
    logic signed [SCW-1:0]      r_a, r_v;

    // blend
    logic signed [WW:0]         w_wa, w_wv;
    logic [WW-1:0]              w_wcomp;
    logic signed [BLW-1:0]      w_p1, w_p2;
    logic signed [BLW-1:0]      r_p1, r_p2, r_bsum;
    logic [BLW-1:0]             w_bmag, w_bq;
    logic signed [SCW-1:0]      w_bround, w_blended;

    logic                       r_out_valid;
    logic [INW-1:0]             r_o_near, r_o_far;
    logic                       r_o_sv;
    logic signed [SCW-1:0]      r_o_adm, r_o_bl;
    logic [COSTW-1:0]           r_o_cost;

    assign w_nm = i_near_mine[BIN_BITS-1:0];
    assign w_nt = i_near_theirs[BIN_BITS-1:0];
    assign w_fm = i_far_mine[BIN_BITS-1:0];
    assign w_ft = i_far_theirs[BIN_BITS-1:0];

    assign w_nmin = (w_nm < w_nt) ? w_nm : w_nt;
    assign w_nmax = (w_nm < w_nt) ? w_nt : w_nm;
    assign w_fmin = (w_fm < w_ft) ? w_fm : w_ft;
    assign w_fmax = (w_fm < w_ft) ? w_ft : w_fm;

    always_comb begin
        if (i_depth_bins < DBW'(2)) begin
            w_db_c = DBW'(2);
        end else if (i_depth_bins > Z_MAX) begin
            w_db_c = Z_MAX;
        end else begin
            w_db_c = i_depth_bins;
        end
    end

    assign w_z   = w_db_c[Z_W-1:0];
    assign w_zm1 = BIN_BITS'(w_z - Z_W'(1));

    assign w_env_step = $signed(ESTEP_W'(w_nmin)) + $signed(ESTEP_W'(w_zm1))
                      - $signed(ESTEP_W'(w_fmax));

    assign w_vmin  = (i_vis_mine < i_vis_theirs) ? i_vis_mine : i_vis_theirs;
    assign w_vmax  = (i_vis_mine < i_vis_theirs) ? i_vis_theirs : i_vis_mine;
    assign w_vdiff = w_vmax - w_vmin;
    assign w_top   = {w_zm1, 4'b0000};
    assign w_vis_step = $signed(VSW'(w_top)) - $signed(VSW'(w_vdiff));

    assign w_cstep = CSTEP_W'(w_nmax - w_nmin) + CSTEP_W'(w_fmax - w_fmin);
    assign w_csum  = {1'b0, r_cost} + (COSTW + 1)'(w_cstep);
    assign w_room  = (r_cnt < CNT_W'(MAX_CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_vis  <= '0;
            r_cost <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.finish) begin
            r_env  <= '0;
            r_vis  <= '0;
            r_cost <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.accum && w_room) begin
            r_env  <= r_env + ENVW'(w_env_step);
            r_vis  <= r_vis + VISW'(w_vis_step);
            r_cost <= w_csum[COSTW] ? {COSTW{1'b1}} : w_csum[COSTW-1:0];
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_den) begin
            r_den <= DEN_W'(r_cnt) * DEN_W'(w_z);
        end
    end

    // magnitude of the scaled sum plus half the divisor, sign kept aside
    assign w_env_prod = PRODW'(r_env) <<< FRACW;
    assign w_vis_prod = PRODW'(r_vis) <<< VSHIFT;
    assign w_env_mag  = r_env[ENVW-1] ? PRODW'(-w_env_prod) : PRODW'(w_env_prod);
    assign w_vis_mag  = r_vis[VISW-1] ? PRODW'(-w_vis_prod) : PRODW'(w_vis_prod);
    assign w_mag      = (i_cmd.div_sel == etc_pkg::DIV_SEL_V) ? w_vis_mag : w_env_mag;
    assign w_neg      = (i_cmd.div_sel == etc_pkg::DIV_SEL_V) ? r_vis[VISW-1] : r_env[ENVW-1];
    assign w_num      = NUMW'(w_mag) + NUMW'(r_den >> 1);

    etc_div #(
        .NUM_W (NUMW),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_qsat  = (w_quo > NUMW'(etc_pkg::SCORE_LIM)) ? SCW'(etc_pkg::SCORE_LIM)
                                                         : w_quo[SCW-1:0];
    assign w_score = w_neg ? SCW'(-$signed(w_qsat)) : $signed(w_qsat);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_q) begin
            if (i_cmd.div_sel == etc_pkg::DIV_SEL_V) begin
                r_v <= w_score;
            end else begin
                r_a <= w_score;
            end
        end
    end

    assign w_wcomp = WW'(etc_pkg::ONE) - i_admissibility;
    assign w_wa    = $signed({1'b0, i_admissibility});
    assign w_wv    = $signed({1'b0, w_wcomp});
    assign w_p1    = BLW'(w_wa) * BLW'(r_a);
    assign w_p2    = BLW'(w_wv) * BLW'(r_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1 <= w_p1;
            r_p2 <= w_p2;
        end
        if (i_cmd.sum) begin
            r_bsum <= r_p1 + r_p2;
        end
    end

    assign w_bmag    = r_bsum[BLW-1] ? BLW'(-r_bsum) : BLW'(r_bsum);
    assign w_bq      = (w_bmag + BLW'(etc_pkg::ONE / 2)) >> FRACW;
    assign w_bround  = r_bsum[BLW-1] ? SCW'(-$signed(w_bq[SCW-1:0]))
                                     : $signed(w_bq[SCW-1:0]);
    assign w_blended = i_admissibility[ADMW-1] ? r_a : w_bround;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_plain || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_plain || i_cmd.load_merge) begin
            r_o_near <= INW'(w_nmax);
            r_o_far  <= INW'(w_fmin);
        end
        if (i_cmd.load_plain) begin
            r_o_sv   <= 1'b0;
            r_o_adm  <= '0;
            r_o_bl   <= '0;
            r_o_cost <= '0;
        end else if (i_cmd.finish) begin
            r_o_sv   <= 1'b1;
            r_o_adm  <= r_a;
            r_o_bl   <= w_blended;
            r_o_cost <= r_cost;
        end
    end

    assign o_sts.out_valid    = r_out_valid;
    assign o_sts.div_done     = w_div_done;
    assign o_out_valid        = r_out_valid;
    assign o_merged_near      = r_o_near;
    assign o_merged_far       = r_o_far;
    assign o_scores_valid     = r_o_sv;
    assign o_env_score        = r_o_adm;
    assign o_blended_score    = r_o_bl;
    assign o_pair_cost        = r_o_cost;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CELLS))
        else $error("cell count beyond limit");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load_plain || i_cmd.finish))
        else $error("output word appeared without a load");

endmodule

`default_nettype wire

// File: rtl/envelope_template_compare.sv
// Non-final cell: one word per cycle if output not stalled; result out the cycle after it is taken.
// Final cell: result word goes through DEN, divide A, divide V, MUL, SUM and FIN states, using one
//   shared 41-step restoring divider run twice (envelope score, then visual score) plus blend.
// A cell is taken while the previous word waits only if m_axis_tready takes that word the same cycle.
// Reset (i_rst_n low, synchronous): sums, cell count, state and output valid cleared;
//   depth_bins returns to 16 and admissibility to 65536.
`default_nettype none

module envelope_template_compare #(
    parameter int MAX_CELLS = etc_pkg::MAX_CELLS_DEF,
    parameter int BIN_BITS  = etc_pkg::BIN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // near_mine[7:0] near_theirs[15:8] far_mine[23:16] far_theirs[31:24]
    // vis_mine[43:32] vis_theirs[55:44]
    input  wire logic [55:0]                       s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // merged_near[7:0] merged_far[15:8] env_score[34:16]
    // blended_score[53:35] pair_cost[75:54] zero[79:76]
    output logic [79:0]                            m_axis_tdata,
    // scores_valid[0]
    output logic                                   m_axis_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [etc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [etc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [etc_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int DW = etc_pkg::CFG_DATA_W;

    logic [etc_pkg::DB_W-1:0]  r_depth_bins;
    logic [etc_pkg::ADM_W-1:0] r_admissibility;
    etc_pkg::t_reg_idx         w_idx;
    etc_pkg::t_cmd             w_cmd;
    etc_pkg::t_sts             w_sts;

    logic [etc_pkg::IN_W-1:0]         w_merged_near, w_merged_far;
    logic                             w_scores_valid;
    logic signed [etc_pkg::SCORE_W-1:0] w_adm_score, w_bl_score;
    logic [etc_pkg::COST_W-1:0]       w_pair_cost;

    assign pready = 1'b1;
    assign w_idx  = etc_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_bins    <= etc_pkg::DB_RESET;
            r_admissibility <= etc_pkg::ADM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                etc_pkg::REG_DEPTH_BINS:    r_depth_bins    <= pwdata[etc_pkg::DB_W-1:0];
                etc_pkg::REG_ADMISSIBILITY: r_admissibility <= pwdata[etc_pkg::ADM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            etc_pkg::REG_DEPTH_BINS:    prdata = DW'(r_depth_bins);
            etc_pkg::REG_ADMISSIBILITY: prdata = DW'(r_admissibility);
            default:                    prdata = '0;
        endcase
    end

    etc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_ready     (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    etc_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .BIN_BITS  (BIN_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_near_mine        (s_axis_tdata[7:0]),
        .i_near_theirs      (s_axis_tdata[15:8]),
        .i_far_mine         (s_axis_tdata[23:16]),
        .i_far_theirs       (s_axis_tdata[31:24]),
        .i_vis_mine         (s_axis_tdata[43:32]),
        .i_vis_theirs       (s_axis_tdata[55:44]),
        .i_depth_bins       (r_depth_bins),
        .i_admissibility    (r_admissibility),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_merged_near      (w_merged_near),
        .o_merged_far       (w_merged_far),
        .o_scores_valid     (w_scores_valid),
        .o_env_score        (w_adm_score),
        .o_blended_score    (w_bl_score),
        .o_pair_cost        (w_pair_cost)
    );

    assign m_axis_tdata = {4'b0000, w_pair_cost, w_bl_score, w_adm_score,
                           w_merged_far, w_merged_near};
    assign m_axis_tuser = w_scores_valid;

endmodule

`default_nettype wire

// File: tb/envelope_template_compare_test.sv
`default_nettype none

module envelope_template_compare_test;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  RANDOM_CELLS   = 350;
    localparam int  LONG_CELLS     = 120;
    localparam longint COST_MAX    = (longint'(1) << etc_pkg::COST_W) - 1;

    typedef struct {
        logic [7:0]  near_mine;
        logic [7:0]  near_theirs;
        logic [7:0]  far_mine;
        logic [7:0]  far_theirs;
        logic [11:0] vis_mine;
        logic [11:0] vis_theirs;
        logic        last_cell;
    } t_cell;

    typedef struct {
        logic [7:0]                  merged_near;
        logic [7:0]                  merged_far;
        logic                        scores_valid;
        logic [etc_pkg::SCORE_W-1:0] env_score;
        logic [etc_pkg::SCORE_W-1:0] blended_score;
        logic [etc_pkg::COST_W-1:0]  pair_cost;
    } t_merged;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [55:0]                    s_axis_tdata = '0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [79:0]                    m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [etc_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [etc_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [etc_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // envelope model state
    logic [etc_pkg::DB_W-1:0]  cfg_depth_bins = etc_pkg::DB_RESET;
    logic [etc_pkg::ADM_W-1:0] cfg_admissibility = etc_pkg::ADM_RESET;
    longint           env_acc = 0;
    longint           vis_acc = 0;
    longint           cost_acc = 0;
    int               cell_cnt = 0;

    t_merged pending_merges[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      rx_stall_left = 0;
    int      rx_hold_req = 0;
    bit      rx_steady = 1'b0;
    bit      tx_steady = 1'b0;

    envelope_template_compare DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip_score(longint v);
        if (v > etc_pkg::SCORE_LIM) return etc_pkg::SCORE_LIM;
        if (v < -etc_pkg::SCORE_LIM) return -etc_pkg::SCORE_LIM;
        return v;
    endfunction

    function automatic longint wrap_bits(longint v, int width);
        return (v <<< (64 - width)) >>> (64 - width);
    endfunction

    function automatic t_merged merge_cell(t_cell c);
        longint  z, nm, nt, fm, ft, vm, vt, top;
        longint  env, vis, cost_step, den, a, v, w, blend;
        t_merged r;
        z = cfg_depth_bins;
        if (z < 2) z = 2;
        if (z > (longint'(1) << etc_pkg::BIN_BITS_DEF))
            z = longint'(1) << etc_pkg::BIN_BITS_DEF;
        nm = c.near_mine;
        nt = c.near_theirs;
        fm = c.far_mine;
        ft = c.far_theirs;
        vm = c.vis_mine;
        vt = c.vis_theirs;
        r.merged_near = (nm > nt) ? nm[7:0] : nt[7:0];
        r.merged_far  = (fm < ft) ? fm[7:0] : ft[7:0];
        if (cell_cnt < etc_pkg::MAX_CELLS_DEF) begin
            env = ((nm < nt) ? nm : nt) + ((fm > ft) ? z - 1 - fm : z - 1 - ft);
            top = (z - 1) * 16;
            vis = ((vm < vt) ? vm : vt) + ((vm > vt) ? top - vm : top - vt);
            cost_step = ((nm > nt) ? nm - nt : nt - nm) + ((fm > ft) ? fm - ft : ft - fm);
            env_acc = wrap_bits(env_acc + env, etc_pkg::ENV_W);
            vis_acc = wrap_bits(vis_acc + vis, etc_pkg::VIS_W);
            cost_acc = (cost_acc + cost_step > COST_MAX) ? COST_MAX : cost_acc + cost_step;
            cell_cnt++;
        end
        r.scores_valid  = 1'b0;
        r.env_score     = '0;
        r.blended_score = '0;
        r.pair_cost     = '0;
        if (c.last_cell) begin
            den = longint'(cell_cnt) * z;
            a = clip_score(div_nearest(env_acc * etc_pkg::ONE, den));
            blend = a;
            if (cfg_admissibility < etc_pkg::ONE) begin
                v = clip_score(div_nearest(vis_acc * 4096, den));
                w = cfg_admissibility;
                blend = div_nearest(w * a + (etc_pkg::ONE - w) * v, etc_pkg::ONE);
            end
            r.scores_valid  = 1'b1;
            r.env_score     = a[etc_pkg::SCORE_W-1:0];
            r.blended_score = blend[etc_pkg::SCORE_W-1:0];
            r.pair_cost     = cost_acc[etc_pkg::COST_W-1:0];
            env_acc  = 0;
            vis_acc  = 0;
            cost_acc = 0;
            cell_cnt = 0;
        end
        return r;
    endfunction

    function automatic t_cell mk_cell(int nm, int nt, int fm, int ft, int vm, int vt,
                                      bit is_last);
        t_cell c;
        c.near_mine   = nm;
        c.near_theirs = nt;
        c.far_mine    = fm;
        c.far_theirs  = ft;
        c.vis_mine    = vm;
        c.vis_theirs  = vt;
        c.last_cell   = is_last;
        return c;
    endfunction

    function automatic t_cell random_cell(bit extreme, bit is_last);
        t_cell c;
        if (extreme) begin
            c = mk_cell($urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 1) ? 255 : 0,
                        $urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 1) ? 255 : 0,
                        $urandom_range(0, 1) ? 4095 : 0, $urandom_range(0, 1) ? 4095 : 0,
                        is_last);
        end else begin
            c = mk_cell($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 4095), $urandom_range(0, 4095), is_last);
        end
        return c;
    endfunction

    task automatic flag_mismatch(string field, longint want, longint got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", field, want, got);
    endtask

    // predicted word for every accepted cell
    always @(posedge i_clk) begin : take_cell
        t_cell c;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            c = mk_cell(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                        s_axis_tdata[31:24], s_axis_tdata[43:32], s_axis_tdata[55:44],
                        s_axis_tlast);
            pending_merges = {pending_merges, merge_cell(c)};
        end
    end

    always @(posedge i_clk) begin : check_word
        t_merged got;
        t_merged want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.merged_near   = m_axis_tdata[7:0];
            got.merged_far    = m_axis_tdata[15:8];
            got.env_score     = m_axis_tdata[34:16];
            got.blended_score = m_axis_tdata[53:35];
            got.pair_cost     = m_axis_tdata[75:54];
            got.scores_valid  = m_axis_tuser;
            if (pending_merges.size() == 0) begin
                flag_mismatch("unexpected word, merged_near", 0, got.merged_near);
            end else begin
                want = pending_merges.pop_front();
                if (got.merged_near !== want.merged_near)
                    flag_mismatch("merged_near", want.merged_near, got.merged_near);
                if (got.merged_far !== want.merged_far)
                    flag_mismatch("merged_far", want.merged_far, got.merged_far);
                if (got.scores_valid !== want.scores_valid)
                    flag_mismatch("scores_valid", want.scores_valid, got.scores_valid);
                if (got.env_score !== want.env_score)
                    flag_mismatch("env_score", $signed(want.env_score),
                                  $signed(got.env_score));
                if (got.blended_score !== want.blended_score)
                    flag_mismatch("blended_score", $signed(want.blended_score),
                                  $signed(got.blended_score));
                if (got.pair_cost !== want.pair_cost)
                    flag_mismatch("pair_cost", want.pair_cost, got.pair_cost);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (rx_hold_req > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = rx_hold_req - 1;
            rx_hold_req = 0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = $urandom_range(10, 60);
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cell(t_cell c);
        int gap;
        int r;
        gap = 0;
        if (!tx_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 93) gap = $urandom_range(10, 40);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tdata  <= {c.vis_theirs, c.vis_mine, c.far_theirs, c.far_mine,
                          c.near_theirs, c.near_mine};
        s_axis_tlast  <= c.last_cell;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic finish_burst;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_merges.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(etc_pkg::t_reg_idx idx, logic [etc_pkg::CFG_DATA_W-1:0] value);
        logic [etc_pkg::CFG_DATA_W-1:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == etc_pkg::REG_DEPTH_BINS) begin
            cfg_depth_bins = value[etc_pkg::DB_W-1:0];
            stored = cfg_depth_bins;
        end else begin
            cfg_admissibility = value[etc_pkg::ADM_W-1:0];
            stored = cfg_admissibility;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored)
            flag_mismatch("register readback", stored, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int depth_bins, int weight);
        finish_burst();
        repeat (4) @(posedge i_clk);
        reg_write(etc_pkg::REG_DEPTH_BINS, depth_bins);
        reg_write(etc_pkg::REG_ADMISSIBILITY, weight);
    endtask

    task automatic test_register_defaults;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {etc_pkg::REG_DEPTH_BINS, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== etc_pkg::CFG_DATA_W'(etc_pkg::DB_RESET))
            flag_mismatch("depth_bins after reset", etc_pkg::DB_RESET, prdata);
        @(negedge i_clk);
        penable <= 1'b0;
        paddr   <= {etc_pkg::REG_ADMISSIBILITY, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== etc_pkg::CFG_DATA_W'(etc_pkg::ADM_RESET))
            flag_mismatch("admissibility after reset", etc_pkg::ADM_RESET, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_field_extremes;
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 1));
        send_cell(mk_cell(255, 255, 255, 255, 4095, 4095, 1));
        send_cell(mk_cell(255, 0, 0, 255, 4095, 0, 0));
        send_cell(mk_cell(0, 255, 255, 0, 0, 4095, 0));
        send_cell(mk_cell(17, 200, 3, 250, 100, 3000, 1));
        send_cell(mk_cell(15, 15, 0, 0, 256, 256, 1));
        send_cell(mk_cell(8, 7, 8, 7, 128, 127, 0));
        send_cell(mk_cell(170, 85, 85, 170, 2730, 1365, 1));
    endtask

    // depth clamping at both ends, blend weights from zero to above one
    task automatic test_depth_and_blend;
        set_config(0, 0);
        send_cell(mk_cell(255, 255, 0, 0, 4095, 4095, 1));
        send_cell(mk_cell(0, 0, 255, 255, 0, 0, 1));
        set_config(1, 65535);
        send_cell(mk_cell(1, 0, 1, 0, 16, 0, 0));
        send_cell(mk_cell(0, 1, 0, 2, 3, 40, 1));
        set_config(511, 131071);
        send_cell(mk_cell(200, 100, 255, 250, 4000, 100, 1));
        set_config(256, 1);
        send_cell(mk_cell(255, 254, 0, 1, 4095, 4080, 0));
        send_cell(mk_cell(3, 250, 9, 255, 7, 4095, 1));
        set_config(2, 32768);
        send_cell(mk_cell(1, 1, 0, 0, 16, 16, 1));
        set_config(257, 65536);
        send_cell(mk_cell(128, 64, 32, 16, 2048, 1024, 1));
        set_config(etc_pkg::DB_RESET, etc_pkg::ADM_RESET);
    endtask

    // one long pair, then a single-cell pair, with no gaps on either side
    task automatic test_long_pair;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < LONG_CELLS; i++)
            send_cell(random_cell(1'b0, i == LONG_CELLS - 1));
        send_cell(mk_cell(9, 4, 2, 11, 300, 200, 1));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        finish_burst();
    endtask

    task automatic test_backpressure;
        @(posedge i_clk);
        rx_hold_req = 300;
        tx_steady = 1'b1;
        for (int i = 0; i < 60; i++)
            send_cell(random_cell(1'b0, 1'b0));
        tx_steady = 1'b0;
        finish_burst();
        send_cell(random_cell(1'b0, 1'b1));
    endtask

    task automatic test_random_pairs;
        int sent;
        int len;
        int r;
        int depth_bins;
        int weight;
        bit extreme;
        sent = 0;
        while (sent < RANDOM_CELLS) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 6);
                depth_bins = (r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 256 :
                             (r == 3) ? 511 : $urandom_range(0, 511);
                r = $urandom_range(0, 6);
                weight = (r == 0) ? 0 : (r == 1) ? 65535 : (r == 2) ? 65536 :
                         (r == 3) ? 131071 : $urandom_range(0, 131071);
                set_config(depth_bins, weight);
            end
            r = $urandom_range(0, 99);
            len = (r < 80) ? $urandom_range(1, 12) :
                  (r < 97) ? $urandom_range(13, 40) : $urandom_range(41, 120);
            extreme = ($urandom_range(0, 4) == 0);
            tx_steady = ($urandom_range(0, 6) == 0);
            rx_steady = ($urandom_range(0, 6) == 0);
            for (int i = 0; i < len; i++)
                send_cell(random_cell(extreme, i == len - 1));
            sent += len;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_defaults();
        test_field_extremes();
        test_depth_and_blend();
        test_long_pair();
        test_backpressure();
        test_random_pairs();
        finish_burst();
        repeat (100) @(posedge i_clk);
        if (pending_merges.size() != 0) begin
            $display("%0d expected words never arrived", pending_merges.size());
            error_count += pending_merges.size();
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
